/* src/xorshift64star_range_generator_defines.svh */
// assertion macros for the range generator
`ifndef XORSHIFT64STAR_RANGE_GENERATOR_DEFINES_SVH
`define XORSHIFT64STAR_RANGE_GENERATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define XRG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("xrg assertion failed");
`define XRG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("xrg assertion failed");
`else
`define XRG_ASSERT_IMP(label, ante, cons)
`define XRG_ASSERT_NXT(label, ante, cons)
`endif

`endif

/* src/xrg_pkg.sv */
`timescale 1ns / 1ps

package xrg_pkg;

  localparam int unsigned STATE_W  = 64;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned SPAN_W   = DATA_W + 1;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DIV_CNT_W = 6;

  localparam logic [STATE_W-1:0] MULT_STAR = 64'd2685821657736338717;
  localparam int unsigned SHIFT_A = 12;
  localparam int unsigned SHIFT_B = 25;
  localparam int unsigned SHIFT_C = 27;
  localparam logic [SPAN_W-1:0] PCT_SPAN = 33'd100;
  localparam logic signed [DATA_W-1:0] PCT_MAX = 32'sd99;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST_CNT = '0;
  localparam logic [DIV_CNT_W-1:0] DIV_FIRST_CNT = '1;

  // address bit that selects the seed register
  localparam int unsigned REG_SEL_BIT = 3;
  localparam logic REG_INTERNAL_SEED = 1'b0;
  localparam logic REG_EXTERNAL_SEED = 1'b1;

  localparam logic FUNC_RANGE = 1'b0;
  localparam logic FUNC_PCT   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_STEP,
    ST_MUL_LL,
    ST_MUL_HL,
    ST_MUL_LH,
    ST_DIV,
    ST_DONE
  } xrg_state_t;

  typedef enum logic [1:0] {
    MUL_LL,
    MUL_HL,
    MUL_LH
  } mul_phase_t;

  typedef struct packed {
    logic       load_in;
    logic       check;
    logic       step;
    logic       mul_en;
    mul_phase_t mul_phase;
    logic       div_en;
    logic       out_load;
  } xrg_cmd_t;

  typedef struct packed {
    logic trivial;
    logic div_last;
    logic out_free;
  } xrg_status_t;

  function automatic logic [STATE_W-1:0] xorshift_next(input logic [STATE_W-1:0] s);
    logic [STATE_W-1:0] v;
    v = s;
    v = v ^ (v >> SHIFT_A);
    v = v ^ (v << SHIFT_B);
    v = v ^ (v >> SHIFT_C);
    return v;
  endfunction

endpackage

/* src/xrg_ctrl.sv */
`timescale 1ns / 1ps

module xrg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  xrg_pkg::xrg_status_t status,
  output xrg_pkg::xrg_cmd_t    cmd,
  output xrg_pkg::xrg_state_t  state
);
  import xrg_pkg::*;

  xrg_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = status.trivial ? ST_DONE : ST_STEP;
      end
      ST_STEP:   state_next = ST_MUL_LL;
      ST_MUL_LL: state_next = ST_MUL_HL;
      ST_MUL_HL: state_next = ST_MUL_LH;
      ST_MUL_LH: state_next = ST_DIV;
      ST_DIV: begin
        if (status.div_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mul_phase = MUL_LL;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      ST_CHECK: cmd.check = 1'b1;
      ST_STEP:  cmd.step = 1'b1;
      ST_MUL_LL: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_phase = MUL_LL;
      end
      ST_MUL_HL: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_phase = MUL_HL;
      end
      ST_MUL_LH: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_phase = MUL_LH;
      end
      ST_DIV:  cmd.div_en = 1'b1;
      ST_DONE: cmd.out_load = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

/* src/xrg_datapath.sv */
`timescale 1ns / 1ps

module xrg_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  xrg_pkg::xrg_cmd_t             cmd,
  output xrg_pkg::xrg_status_t          status,
  // seed registers
  input  logic                          cfg_we,
  input  logic [xrg_pkg::ADDR_W-1:0]    cfg_addr,
  input  logic [xrg_pkg::STATE_W-1:0]   cfg_wdata,
  output logic [xrg_pkg::STATE_W-1:0]   cfg_rdata,
  // request word
  input  logic                          func,
  input  logic                          use_external,
  input  logic signed [xrg_pkg::DATA_W-1:0] range_min,
  input  logic signed [xrg_pkg::DATA_W-1:0] range_max,
  input  logic signed [xrg_pkg::DATA_W-1:0] chance_pct,
  // result word
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic signed [xrg_pkg::DATA_W-1:0] drawn_value,
  output logic                          hit,
  output logic [xrg_pkg::STATE_W-1:0]   internal_snapshot
);
  import xrg_pkg::*;

  logic [STATE_W-1:0] internal_seed;
  logic [STATE_W-1:0] external_seed;
  logic [STATE_W-1:0] internal_state;
  logic [STATE_W-1:0] external_state;

  logic                     func_r;
  logic                     sel_ext;
  logic signed [DATA_W-1:0] lo;
  logic signed [DATA_W-1:0] hi;
  logic signed [DATA_W-1:0] pct;
  logic [SPAN_W-1:0]        span;
  logic                     trivial;
  logic                     pct_high;
  logic [STATE_W-1:0]       gen_val;
  logic [STATE_W-1:0]       prod;
  logic [SPAN_W-1:0]        rem;
  logic [DIV_CNT_W-1:0]     div_cnt;

  logic [STATE_W-1:0] int_seed_next;
  logic [STATE_W-1:0] ext_seed_next;
  logic [STATE_W-1:0] int_load;
  logic [STATE_W-1:0] stepped;
  logic               pct_low_now;
  logic               pct_high_now;
  logic               trivial_now;
  logic [SPAN_W-1:0]  span_now;
  logic [DATA_W-1:0]  mul_x;
  logic [DATA_W-1:0]  mul_y;
  logic [STATE_W-1:0] mul_full;
  logic [SPAN_W:0]    rem_sh;
  logic [SPAN_W:0]    rem_sub;

  // re-seed from the register values as they stand after this write
  always_comb begin
    int_seed_next = internal_seed;
    ext_seed_next = external_seed;
    if (cfg_addr[REG_SEL_BIT] == REG_EXTERNAL_SEED) begin
      ext_seed_next = cfg_wdata;
    end else begin
      int_seed_next = cfg_wdata;
    end
    int_load = (int_seed_next == '0) ? ext_seed_next + 64'd1 : int_seed_next;
  end

  assign cfg_rdata = (cfg_addr[REG_SEL_BIT] == REG_EXTERNAL_SEED) ? external_seed
                                                                   : internal_seed;

  assign stepped = xorshift_next(sel_ext ? external_state : internal_state);

  always_ff @(posedge clk) begin
    if (rst) begin
      internal_seed  <= '0;
      external_seed  <= 64'd1;
      internal_state <= 64'd2;
      external_state <= 64'd1;
    end else if (cfg_we) begin
      internal_seed  <= int_seed_next;
      external_seed  <= ext_seed_next;
      internal_state <= int_load;
      external_state <= ext_seed_next;
    end else if (cmd.step) begin
      if (sel_ext) begin
        external_state <= stepped;
      end else begin
        internal_state <= stepped;
      end
    end
  end

  // request capture, bounds put in order
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r  <= func;
      sel_ext <= use_external && (func == FUNC_RANGE);
      lo      <= (range_min > range_max) ? range_max : range_min;
      hi      <= (range_min > range_max) ? range_min : range_max;
      pct     <= chance_pct;
    end
  end

  assign pct_low_now  = pct < 32'sd1;
  assign pct_high_now = pct > PCT_MAX;
  assign span_now = (func_r == FUNC_PCT) ? PCT_SPAN
                  : SPAN_W'({hi[DATA_W-1], hi} - {lo[DATA_W-1], lo} + 33'd1);
  assign trivial_now = (func_r == FUNC_PCT) ? (pct_low_now || pct_high_now) : (lo == hi);

  // one shared 32x32 multiplier builds the low 64 bits of the product
  always_comb begin
    mul_x = gen_val[DATA_W-1:0];
    mul_y = MULT_STAR[DATA_W-1:0];
    case (cmd.mul_phase)
      MUL_HL: begin
        mul_x = gen_val[STATE_W-1:DATA_W];
        mul_y = MULT_STAR[DATA_W-1:0];
      end
      MUL_LH: begin
        mul_x = gen_val[DATA_W-1:0];
        mul_y = MULT_STAR[STATE_W-1:DATA_W];
      end
      default: begin
        mul_x = gen_val[DATA_W-1:0];
        mul_y = MULT_STAR[DATA_W-1:0];
      end
    endcase
    mul_full = STATE_W'(mul_x) * STATE_W'(mul_y);
  end

  // restoring remainder, one dividend bit per cycle
  assign rem_sh  = {rem, prod[STATE_W-1]};
  assign rem_sub = rem_sh - {1'b0, span};

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      span     <= span_now;
      trivial  <= trivial_now;
      pct_high <= pct_high_now;
      rem      <= '0;
      div_cnt  <= DIV_FIRST_CNT;
    end
    if (cmd.step) begin
      gen_val <= stepped;
    end
    if (cmd.mul_en) begin
      if (cmd.mul_phase == MUL_LL) begin
        prod <= mul_full;
      end else begin
        prod <= prod + {mul_full[DATA_W-1:0], {DATA_W{1'b0}}};
      end
    end
    if (cmd.div_en) begin
      prod    <= {prod[STATE_W-2:0], 1'b0};
      div_cnt <= div_cnt - 1'b1;
      if (rem_sh >= {1'b0, span}) begin
        rem <= rem_sub[SPAN_W-1:0];
      end else begin
        rem <= rem_sh[SPAN_W-1:0];
      end
    end
  end

  assign status.trivial  = trivial_now;
  assign status.div_last = (div_cnt == DIV_LAST_CNT);
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // remainder is zero on the trivial paths, so drawn value falls back to lo
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      internal_snapshot <= internal_state;
      if (func_r == FUNC_PCT) begin
        drawn_value <= '0;
        hit         <= trivial ? pct_high : (rem[6:0] < pct[6:0]);
      end else begin
        drawn_value <= lo + $signed(rem[DATA_W-1:0]);
        hit         <= 1'b0;
      end
    end
  end

endmodule

/* src/xorshift64star_range_generator.sv */
`timescale 1ns / 1ps
// Range and percent-chance draws from two xorshift64* generators (internal and
// external). Each request word gives one result word. A draw that needs the
// generator checks the request, takes an xorshift step, builds the 64-bit
// product from the low-low, high-low and low-high partial products on the
// shared 32x32 multiplier, runs the bit-serial remainder unit over every bit
// of that product and then loads the output register. Equal bounds and
// percent chances below 1 or above 99 go from the check straight to the output
// register and leave both generators as they were. The next request is taken
// only after the previous result has moved into the output register, so a
// result held there by out_stall holds up the next request. Writing either
// seed register reloads both generators; an internal seed of zero loads the
// external seed plus one.

module xorshift64star_range_generator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [xrg_pkg::ADDR_W-1:0]         paddr,
  input  logic [xrg_pkg::STATE_W-1:0]        pwdata,
  output logic [xrg_pkg::STATE_W-1:0]        prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               func,
  input  logic                               use_external,
  input  logic signed [xrg_pkg::DATA_W-1:0]  range_min,
  input  logic signed [xrg_pkg::DATA_W-1:0]  range_max,
  input  logic signed [xrg_pkg::DATA_W-1:0]  chance_pct,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [xrg_pkg::DATA_W-1:0]  drawn_value,
  output logic                               hit,
  output logic [xrg_pkg::STATE_W-1:0]        internal_snapshot
);
  import xrg_pkg::*;

`include "xorshift64star_range_generator_defines.svh"

  xrg_cmd_t    cmd;
  xrg_status_t status;
  xrg_state_t  state;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  xrg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd),
    .state    (state)
  );

  xrg_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_we),
    .cfg_addr          (paddr),
    .cfg_wdata         (pwdata),
    .cfg_rdata         (prdata),
    .func              (func),
    .use_external      (use_external),
    .range_min         (range_min),
    .range_max         (range_max),
    .chance_pct        (chance_pct),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .drawn_value       (drawn_value),
    .hit               (hit),
    .internal_snapshot (internal_snapshot)
  );

  `XRG_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `XRG_ASSERT_IMP(a_load_only_when_free, cmd.out_load, !out_valid || !out_stall)
  `XRG_ASSERT_IMP(a_pct_hit_zero_value, out_valid && hit, drawn_value == '0)
  `XRG_ASSERT_IMP(a_accept_only_idle, in_valid && !in_stall, state == ST_IDLE)

endmodule
